// ----- rtl/bam_pkg.sv -----
// ----------------------------------------------------------------------------
// bam_pkg
// Shared types and constants for the broadcast anomaly monitor: register
// indexes, record codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package bam_pkg;

  // element counters
  localparam int unsigned CNT_W = 13;
  localparam logic [CNT_W-1:0] ELEM_MAX = 13'd4096;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 31;
  localparam logic [CFG_IDX_W-1:0] CFG_DETECT_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAPID_LIMIT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STREAK_LIMIT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIJACK_WINDOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CORRUPT_FRAC    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTREME_MAG     = 3'd5;

  // configuration reset values
  localparam logic        RST_DETECT_ENABLE = 1'b1;
  localparam logic [15:0] RST_RAPID_LIMIT   = 16'd50;
  localparam logic [7:0]  RST_STREAK_LIMIT  = 8'd3;
  localparam logic [7:0]  RST_HIJACK_WINDOW = 8'd5;
  localparam logic [15:0] RST_CORRUPT_FRAC  = 16'd655;
  localparam logic [30:0] RST_EXTREME_MAG   = 31'd1232348160;

  // record codes
  localparam logic [1:0] KIND_RAPID   = 2'd0;
  localparam logic [1:0] KIND_HIJACK  = 2'd1;
  localparam logic [1:0] KIND_CORRUPT = 2'd2;
  localparam logic [1:0] SEV_MODERATE = 2'd0;
  localparam logic [1:0] SEV_SEVERE   = 2'd1;
  localparam logic [1:0] SEV_CRITICAL = 2'd2;

  localparam logic [23:0] SCORE_ONE = 24'h010000;
  localparam logic [23:0] SCORE_MAX = 24'hFFFFFF;
  localparam logic [7:0]  NO_MODULE = 8'd255;
  localparam logic [7:0]  STREAK_MAX = 8'd255;

  // divider: 32 bit dividend, one quotient bit a cycle
  localparam int unsigned DIV_STEPS = 32;
  localparam logic [5:0]  DIV_STEPS_CNT = 6'd32;

  // stream widths
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 72;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_ROUTE,
    S_DIV_R,
    S_PUT_R,
    S_DIV_H,
    S_PUT_H,
    S_PUT_C
  } bam_state_t;

  typedef struct packed {
    logic accept;       // element word taken this cycle
    logic eval;         // register the anomaly tests
    logic div_rapid;    // start divider with the rapid score operands
    logic div_hijack;   // start divider with the hijack score operands
    logic put_rapid;    // load rapid record into the output register
    logic put_hijack;
    logic put_corrupt;
  } bam_cmd_t;

  typedef struct packed {
    logic enable;
    logic rapid;
    logic hijack;
    logic corrupt;
    logic div_done;
    logic out_free;
  } bam_sts_t;

endpackage

`default_nettype wire

// ----- rtl/bam_ctrl.sv -----
// ----------------------------------------------------------------------------
// bam_ctrl
// Controller: takes element words, and at the end of a broadcast sequences
// the tests, the score divisions and the emission of the records.
// ----------------------------------------------------------------------------
`default_nettype none

module bam_ctrl
  import bam_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  input  wire logic     in_tlast,
  output logic          in_tready,
  input  wire bam_sts_t sts,
  output bam_cmd_t      cmd
);

  bam_state_t state_r, state_nxt;
  logic       take;

  assign take = in_tvalid && (state_r == S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (take && in_tlast && sts.enable) state_nxt = S_EVAL;
      end
      S_EVAL:  state_nxt = S_ROUTE;
      S_ROUTE: begin
        if (sts.rapid)        state_nxt = S_DIV_R;
        else if (sts.hijack)  state_nxt = S_DIV_H;
        else if (sts.corrupt) state_nxt = S_PUT_C;
        else                  state_nxt = S_IDLE;
      end
      S_DIV_R: begin
        if (sts.div_done) state_nxt = S_PUT_R;
      end
      S_PUT_R: begin
        if (sts.out_free) begin
          if (sts.hijack)       state_nxt = S_DIV_H;
          else if (sts.corrupt) state_nxt = S_PUT_C;
          else                  state_nxt = S_IDLE;
        end
      end
      S_DIV_H: begin
        if (sts.div_done) state_nxt = S_PUT_H;
      end
      S_PUT_H: begin
        if (sts.out_free) begin
          if (sts.corrupt) state_nxt = S_PUT_C;
          else             state_nxt = S_IDLE;
        end
      end
      S_PUT_C: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd        = '0;
    in_tready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = take;
      end
      S_EVAL:  cmd.eval = 1'b1;
      S_ROUTE: begin
        cmd.div_rapid  = sts.rapid;
        cmd.div_hijack = !sts.rapid && sts.hijack;
      end
      S_PUT_R: begin
        cmd.put_rapid  = sts.out_free;
        cmd.div_hijack = sts.out_free && sts.hijack;
      end
      S_PUT_H: cmd.put_hijack  = sts.out_free;
      S_PUT_C: cmd.put_corrupt = sts.out_free;
      S_DIV_R, S_DIV_H: begin
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/bam_dp.sv -----
// ----------------------------------------------------------------------------
// bam_dp
// Datapath: configuration registers, element counters, broadcast history,
// end-of-broadcast snapshot, a shared radix-2 divider and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bam_dp
  import bam_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // element word
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic                  in_tlast,
  // records
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tlast,
  // control
  input  wire bam_cmd_t              cmd,
  output bam_sts_t                   sts
);

  // configuration registers
  logic        enable_r;
  logic [15:0] rapid_limit_r;
  logic [7:0]  streak_limit_r;
  logic [7:0]  window_r;
  logic [15:0] frac_r;
  logic [30:0] extreme_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r       <= RST_DETECT_ENABLE;
      rapid_limit_r  <= RST_RAPID_LIMIT;
      streak_limit_r <= RST_STREAK_LIMIT;
      window_r       <= RST_HIJACK_WINDOW;
      frac_r         <= RST_CORRUPT_FRAC;
      extreme_r      <= RST_EXTREME_MAG;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DETECT_ENABLE: enable_r       <= cfg_data[0];
        CFG_RAPID_LIMIT:   rapid_limit_r  <= cfg_data[15:0];
        CFG_STREAK_LIMIT:  streak_limit_r <= cfg_data[7:0];
        CFG_HIJACK_WINDOW: window_r       <= cfg_data[7:0];
        CFG_CORRUPT_FRAC:  frac_r         <= cfg_data[15:0];
        CFG_EXTREME_MAG:   extreme_r      <= cfg_data[30:0];
        default: begin
        end
      endcase
    end
  end

  // element fields
  logic [31:0] value_bits;
  logic [7:0]  module_id;
  logic [31:0] time_ms;
  logic [30:0] mag;
  logic        nonfinite;
  logic        is_nan;
  logic        extreme;

  assign value_bits = in_tdata[31:0];
  assign module_id  = in_tdata[39:32];
  assign time_ms    = in_tdata[71:40];
  assign mag        = value_bits[30:0];
  assign nonfinite  = &mag[30:23];
  assign is_nan     = nonfinite && (|mag[22:0]);
  assign extreme    = !is_nan && (mag > extreme_r);

  // element counters, counts including the current word
  logic [CNT_W-1:0] elem_cnt_r, bad_cnt_r, ext_cnt_r;
  logic [CNT_W-1:0] elem_cnt_nxt, bad_cnt_nxt, ext_cnt_nxt;
  logic             room;

  assign room = elem_cnt_r < ELEM_MAX;

  always_comb begin
    elem_cnt_nxt = elem_cnt_r;
    bad_cnt_nxt  = bad_cnt_r;
    ext_cnt_nxt  = ext_cnt_r;
    if (room) begin
      elem_cnt_nxt = elem_cnt_r + CNT_W'(1);
      if (nonfinite) bad_cnt_nxt = bad_cnt_r + CNT_W'(1);
      if (extreme)   ext_cnt_nxt = ext_cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_cnt_r <= '0;
      bad_cnt_r  <= '0;
      ext_cnt_r  <= '0;
    end else if (cmd.accept) begin
      if (in_tlast) begin
        elem_cnt_r <= '0;
        bad_cnt_r  <= '0;
        ext_cnt_r  <= '0;
      end else begin
        elem_cnt_r <= elem_cnt_nxt;
        bad_cnt_r  <= bad_cnt_nxt;
        ext_cnt_r  <= ext_cnt_nxt;
      end
    end
  end

  // broadcast history
  logic        prior_seen_r;
  logic [31:0] prior_time_r;
  logic [7:0]  prior_module_r;
  logic [7:0]  streak_r;
  logic        same_src;
  logic [7:0]  streak_nxt;
  logic        close;

  assign close    = cmd.accept && in_tlast && enable_r;
  assign same_src = prior_seen_r && (module_id == prior_module_r);

  always_comb begin
    if (!same_src)                streak_nxt = 8'd1;
    else if (streak_r < STREAK_MAX) streak_nxt = streak_r + 8'd1;
    else                          streak_nxt = streak_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prior_seen_r   <= 1'b0;
      prior_time_r   <= '0;
      prior_module_r <= NO_MODULE;
      streak_r       <= '0;
    end else if (close) begin
      prior_seen_r   <= 1'b1;
      prior_time_r   <= time_ms;
      prior_module_r <= module_id;
      streak_r       <= streak_nxt;
    end
  end

  // snapshot of the closing broadcast
  logic [CNT_W-1:0] snap_cnt_r, snap_bad_r, snap_ext_r;
  logic [7:0]       snap_mod_r;
  logic [31:0]      snap_time_r;
  logic [31:0]      snap_gap_r;
  logic             snap_seen_r;
  logic             snap_same_r;
  logic [7:0]       snap_streak_r;

  always_ff @(posedge clk) begin
    if (close) begin
      snap_cnt_r    <= elem_cnt_nxt;
      snap_bad_r    <= bad_cnt_nxt;
      snap_ext_r    <= ext_cnt_nxt;
      snap_mod_r    <= module_id;
      snap_time_r   <= time_ms;
      snap_gap_r    <= time_ms - prior_time_r;
      snap_seen_r   <= prior_seen_r;
      snap_same_r   <= same_src;
      snap_streak_r <= streak_nxt;
    end
  end

  // anomaly tests
  logic [28:0] allowed;
  logic        rapid_r, hijack_r, corrupt_r;

  assign allowed = {13'd0, frac_r} * {16'd0, snap_cnt_r};

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      rapid_r   <= snap_seen_r && (snap_gap_r < {16'd0, rapid_limit_r});
      hijack_r  <= snap_same_r && (snap_streak_r >= streak_limit_r);
      corrupt_r <= ({snap_bad_r, 16'd0} > allowed) || ({snap_ext_r, 16'd0} > allowed);
    end
  end

  // shared restoring divider, one quotient bit a cycle
  logic [31:0] quo_r;
  logic [15:0] rem_r;
  logic [15:0] divisor_r;
  logic [5:0]  div_cnt_r;
  logic [16:0] rem_shift;
  logic [16:0] rem_sub;
  logic [15:0] rapid_diff;

  assign rem_shift  = {rem_r, quo_r[DIV_STEPS-1]};
  assign rem_sub    = rem_shift - {1'b0, divisor_r};
  assign rapid_diff = rapid_limit_r - snap_gap_r[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd.div_rapid || cmd.div_hijack) begin
      div_cnt_r <= DIV_STEPS_CNT;
    end else if (div_cnt_r != '0) begin
      div_cnt_r <= div_cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_rapid) begin
      quo_r     <= {rapid_diff, 16'd0};
      rem_r     <= '0;
      divisor_r <= rapid_limit_r;
    end else if (cmd.div_hijack) begin
      quo_r     <= {8'd0, snap_streak_r, 16'd0};
      rem_r     <= '0;
      divisor_r <= {8'd0, window_r};
    end else if (div_cnt_r != '0) begin
      if (rem_shift >= {1'b0, divisor_r}) begin
        rem_r <= rem_sub[15:0];
        quo_r <= {quo_r[DIV_STEPS-2:0], 1'b1};
      end else begin
        rem_r <= rem_shift[15:0];
        quo_r <= {quo_r[DIV_STEPS-2:0], 1'b0};
      end
    end
  end

  // a zero window gives an all-ones quotient, which saturates here
  logic [23:0] div_score;
  assign div_score = (|quo_r[31:24]) ? SCORE_MAX : quo_r[23:0];

  // output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_last_r;
  logic                  put;
  logic [1:0]            rec_kind;
  logic [1:0]            rec_sev;
  logic [23:0]           rec_score;
  logic                  rec_last;

  assign put = cmd.put_rapid || cmd.put_hijack || cmd.put_corrupt;

  always_comb begin
    rec_kind  = KIND_CORRUPT;
    rec_sev   = SEV_CRITICAL;
    rec_score = SCORE_ONE;
    rec_last  = 1'b1;
    if (cmd.put_rapid) begin
      rec_kind  = KIND_RAPID;
      rec_sev   = SEV_MODERATE;
      rec_score = div_score;
      rec_last  = !hijack_r && !corrupt_r;
    end else if (cmd.put_hijack) begin
      rec_kind  = KIND_HIJACK;
      rec_sev   = SEV_SEVERE;
      rec_score = div_score;
      rec_last  = !corrupt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (put) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (put) begin
      out_data_r <= {4'd0, rec_score, snap_time_r, snap_mod_r, rec_sev, rec_kind};
      out_last_r <= rec_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // status to the controller
  assign sts.enable   = enable_r;
  assign sts.rapid    = rapid_r;
  assign sts.hijack   = hijack_r;
  assign sts.corrupt  = corrupt_r;
  assign sts.div_done = (div_cnt_r == '0);
  assign sts.out_free = !out_valid_r || out_tready;

endmodule

`default_nettype wire

// ----- rtl/broadcast_anomaly_monitor_top.sv -----
// ----------------------------------------------------------------------------
// broadcast_anomaly_monitor_top
// Counts bad and extreme float elements of each broadcast and, on its last
// element, emits rapid switching, module hijack and corrupted content records.
// ----------------------------------------------------------------------------
// Element words are taken one per cycle while the block is counting. The
// last word of a broadcast starts an evaluation that holds off the input:
// the tests are registered, then for each rapid or hijack record the
// shared one-bit-per-cycle divider runs 32 steps to form its score, and
// every record is loaded once the output register is free. A record waits
// in the output register until taken; the input opens again as soon as
// the final record is loaded. While detection is disabled a last word is
// taken like any other and no records appear. The configuration port is
// always ready; write it only while the block is idle.
`default_nettype none

module broadcast_anomaly_monitor_top
  import bam_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // element words
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // value_bits[31:0], module_id[39:32],
                                                  // time_ms[71:40]
  input  wire logic                  in_tlast,   // last_element
  // anomaly records
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // anomaly_kind[1:0], severity[3:2],
                                                  // src_module[11:4],
                                                  // event_time_ms[43:12],
                                                  // score_q8_16[67:44], zero[71:68]
  output logic                       out_tlast   // last_of_run
);

  bam_cmd_t cmd;
  bam_sts_t sts;

  assign cfg_ready = 1'b1;

  bam_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bam_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

`default_nettype wire

// ----- rtl/bam_chk.sv -----
// ----------------------------------------------------------------------------
// bam_chk
// Port-level checks on the anomaly record stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bam_chk
  import bam_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic                  out_tlast
);

  // a stalled record holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("record changed while stalled");

  // no record right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("record valid after reset");

  // severity follows kind, and no unused kind
  a_kind_sev: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[3:2] == out_tdata[1:0]) && (out_tdata[1:0] != 2'd3))
    else $error("bad kind or severity");

  // corrupted content closes the run with a score of one
  a_corrupt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == KIND_CORRUPT) |->
      out_tlast && (out_tdata[67:44] == SCORE_ONE))
    else $error("corrupt record malformed");

  // pad bits above the score stay zero
  a_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[71:68] == 4'd0)
    else $error("pad bits set");

endmodule

bind broadcast_anomaly_monitor_top bam_chk u_bam_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
